@@ design/aes_ctr_byte_stream_cipher_core_defines.svh @@
// assertion macros for the aes ctr byte stream cipher core
// no dependencies; included by modules that check their own logic
`ifndef AES_CTR_BYTE_STREAM_CIPHER_CORE_DEFINES_SVH
`define AES_CTR_BYTE_STREAM_CIPHER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ACB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ACB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ACB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ACB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/acb_pkg.sv @@
// shared types, constants and aes helper functions for the ctr byte cipher
// no dependencies
package acb_pkg;

  localparam int unsigned BlockW   = 128;

  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_KSIZE = 3'd4;
  localparam logic [2:0] CFG_IVHI  = 3'd5;
  localparam logic [2:0] CFG_IVLO  = 3'd6;

  localparam logic [1:0] KSIZE_128 = 2'd0;
  localparam logic [1:0] KSIZE_192 = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } acb_state_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

@@ design/acb_engine.sv @@
// iterative aes block encryption: one key schedule word per cycle, a round on every fourth word
// depends on acb_pkg
module acb_engine import acb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [255:0]      key,
  input  logic [1:0]        key_size,
  input  logic [BlockW-1:0] ctr_blk,
  output logic              done,
  output logic [BlockW-1:0] ks_blk
);

  acb_state_t  state_r, state_nxt;
  logic [31:0] win_r [8];
  logic [31:0] rk0_r, rk1_r, rk2_r;
  logic [3:0]  nk_r, nk_in, nr;
  logic [5:0]  widx_r, nwords;
  logic [2:0]  kpos_r, top_idx;
  logic [7:0]  rc_r;
  logic [BlockW-1:0] s_r, s_nxt;
  logic [31:0] tmp, wnew, cw;
  logic        gen, rot_case, sub_case, word_last, rk_full;
  logic [3:0]  rnd;
  logic [BlockW-1:0] sb, sr, mc, rk;

  assign nk_in = (key_size == KSIZE_128) ? 4'd4 : (key_size == KSIZE_192) ? 4'd6 : 4'd8;
  assign nr = nk_r + 4'd6;
  assign nwords = {nr, 2'b00} + 6'd4;
  assign top_idx = nk_r[2:0] - 3'd1;

  // the key schedule keeps the last nk words in a sliding window, win_r[0] is oldest
  assign gen = (widx_r >= {2'b00, nk_r});
  assign rot_case = (kpos_r == 3'd0);
  assign sub_case = (nk_r == 4'd8) && (kpos_r == 3'd4);
  assign word_last = (widx_r == nwords - 6'd1);
  assign rk_full = (widx_r[1:0] == 2'b11);
  assign rnd = widx_r[5:2];

  always_comb begin
    tmp = win_r[top_idx];
    if (rot_case) tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rc_r, 24'd0};
    else if (sub_case) tmp = sub_word(tmp);
    wnew = win_r[0] ^ tmp;
    // the first nk words are the key itself
    cw = gen ? wnew : win_r[widx_r[2:0]];
  end
  assign rk = {rk0_r, rk1_r, rk2_r, cw};

  always_comb begin
    for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = sbox(s_r[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sr[127-8*(c*4+r) -: 8] = sb[127-8*((((c+r)&3)*4)+r) -: 8];
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr[127-32*c -: 8]; a1 = sr[119-32*c -: 8];
      a2 = sr[111-32*c -: 8]; a3 = sr[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mc[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
  end

  // round 0 is the initial key addition, the last round skips the column mix
  always_comb begin
    if (rnd == 4'd0) s_nxt = s_r ^ rk;
    else if (rnd == nr) s_nxt = sr ^ rk;
    else s_nxt = mc ^ rk;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (word_last) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      for (int i = 0; i < 8; i++) win_r[i] <= key[255-32*i -: 32];
      nk_r   <= nk_in;
      widx_r <= '0;
      kpos_r <= '0;
      rc_r   <= 8'h01;
      s_r    <= ctr_blk;
    end else if (state_r == ST_RUN) begin
      widx_r <= widx_r + 6'd1;
      rk0_r <= rk1_r;
      rk1_r <= rk2_r;
      rk2_r <= cw;
      if (gen) begin
        for (int i = 0; i < 7; i++) win_r[i] <= (3'(i) == top_idx) ? wnew : win_r[i+1];
        if (top_idx == 3'd7) win_r[7] <= wnew;
        kpos_r <= (kpos_r == top_idx) ? 3'd0 : kpos_r + 3'd1;
        if (rot_case) rc_r <= xtime(rc_r);
      end
      if (rk_full) s_r <= s_nxt;
    end
  end

  assign ks_blk = s_r;

endmodule

@@ design/aes_ctr_byte_stream_cipher_core.sv @@
// top level of the aes ctr byte stream cipher: config, counter, keystream buffer, byte xor
// depends on acb_pkg, acb_engine and the assertion macro header
//
//  channel | direction | fields
//  in      | input     | in_data_byte, in_last_in
//  out     | output    | out_out_byte, out_last_out
//  cfg     | input     | cfg_index, cfg_data
//
// a byte at offset nonzero gives its result the cycle after it is taken
// a byte at offset zero waits for the aes engine to finish the key schedule and all nr rounds
// and hand over the keystream block (nr = 10, 12, 14)
// reset is synchronous active low and clears config, counter, keystream and offset
// the output register holds a result until taken; a new byte is taken once it is free and no block is pending
`include "aes_ctr_byte_stream_cipher_core_defines.svh"
module aes_ctr_byte_stream_cipher_core import acb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key0_r, key1_r, key2_r, key3_r, iv_hi_r, iv_lo_r;
  logic [1:0]  ksize_r;
  logic [127:0] ctr_r, ks_r;
  logic [3:0]  off_r;
  logic        wait_r;
  logic [7:0]  pend_byte_r;
  logic        pend_last_r;
  logic        eng_done, eng_start, in_acc, out_free, cfg_acc;
  logic [127:0] eng_ks;
  logic [7:0]  ks_byte;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !wait_r && out_free;
  assign in_acc    = in_valid && in_ready;
  assign eng_start = in_acc && (off_r == 4'd0);

  acb_engine u_eng (
    .clk, .rst_n, .start(eng_start),
    .key({key0_r, key1_r, key2_r, key3_r}),
    .key_size(ksize_r), .ctr_blk(ctr_r), .done(eng_done), .ks_blk(eng_ks)
  );

  always_comb begin
    ks_byte = ks_r[127 - {off_r, 3'b000} -: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; key3_r <= '0;
      ksize_r <= KSIZE_128; iv_hi_r <= '0; iv_lo_r <= '0;
      ctr_r <= '0; ks_r <= '0; off_r <= '0; wait_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_KEY0:  key0_r <= cfg_data;
          CFG_KEY1:  key1_r <= cfg_data;
          CFG_KEY2:  key2_r <= cfg_data;
          CFG_KEY3:  key3_r <= cfg_data;
          CFG_KSIZE: ksize_r <= cfg_data[1:0];
          CFG_IVHI: begin
            iv_hi_r <= cfg_data; ctr_r <= {cfg_data, iv_lo_r}; off_r <= '0;
          end
          CFG_IVLO: begin
            iv_lo_r <= cfg_data; ctr_r <= {iv_hi_r, cfg_data}; off_r <= '0;
          end
          default: ;
        endcase
      end
      if (eng_start) begin
        wait_r <= 1'b1;
        pend_byte_r <= in_data_byte;
        pend_last_r <= in_last_in;
        ctr_r <= ctr_r + 128'd1;
      end else if (in_acc) begin
        out_valid <= 1'b1;
        out_out_byte <= in_data_byte ^ ks_byte;
        out_last_out <= in_last_in;
        off_r <= off_r + 4'd1;
      end
      if (wait_r && eng_done) begin
        wait_r <= 1'b0;
        ks_r <= eng_ks;
        out_valid <= 1'b1;
        out_out_byte <= pend_byte_r ^ eng_ks[127:120];
        out_last_out <= pend_last_r;
        off_r <= 4'd1;
      end
    end
  end

  `ACB_ASSERT_IMP(a_no_in_while_wait, clk, rst_n, wait_r, !in_ready)
  `ACB_ASSERT_NXT(a_start_waits, clk, rst_n, eng_start, wait_r)
  `ACB_ASSERT_NXT(a_done_gives_out, clk, rst_n, wait_r && eng_done, out_valid && off_r == 4'd1)

endmodule

@@ verif/aes_ctr_byte_stream_cipher_core_checker.sv @@
// checker for the aes ctr byte stream cipher core: tracks config writes, predicts each output
// byte with its own aes-ctr model and compares; depends on acb_pkg for register codes
module aes_ctr_byte_stream_cipher_core_checker import acb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_out_byte,
  input  logic        out_last_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last;
  } cipher_out_t;

  logic [7:0]   sub_tab [256];
  logic [63:0]  key_reg [4];
  logic [1:0]   ksize_reg;
  logic [63:0]  iv_hi_reg, iv_lo_reg;
  logic [127:0] ctr;
  logic [7:0]   kstream [16];
  logic [3:0]   offset;
  cipher_out_t  expected_bytes [$];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  // s-box built from the field inverse and the affine map
  initial begin
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = b;
    end
  end

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
    logic [7:0]  kb [32];
    logic [31:0] w [60];
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [31:0] tmp;
    logic [7:0]  rc, a0, a1, a2, a3, all;
    logic [127:0] res;
    int nk, nr;
    rc = 8'h01;
    for (int i = 0; i < 32; i++) kb[i] = key_reg[i >> 3][63 - 8 * (i & 7) -: 8];
    nk = (ksize_reg == KSIZE_128) ? 4 : (ksize_reg == KSIZE_192) ? 6 : 8;
    nr = nk + 6;
    for (int i = 0; i < nk; i++) w[i] = {kb[4*i], kb[4*i+1], kb[4*i+2], kb[4*i+3]};
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      tmp = w[i-1];
      if (i % nk == 0) begin
        tmp = subst_word({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk > 6 && i % nk == 4) begin
        tmp = subst_word(tmp);
      end
      w[i] = w[i-nk] ^ tmp;
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8] ^ w[i/4][31 - 8*(i%4) -: 8];
    for (int rnd = 1; rnd <= nr; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = sub_tab[s[i]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[c*4+r] = s[((c + r) & 3) * 4 + r];
      if (rnd != nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          s[c*4]   = a0 ^ all ^ gf_mul(a0 ^ a1, 8'h02);
          s[c*4+1] = a1 ^ all ^ gf_mul(a1 ^ a2, 8'h02);
          s[c*4+2] = a2 ^ all ^ gf_mul(a2 ^ a3, 8'h02);
          s[c*4+3] = a3 ^ all ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end else begin
        s = t;
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ w[4*rnd + i/4][31 - 8*(i%4) -: 8];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
    return res;
  endfunction

  assign pending = expected_bytes.size();

  always @(posedge clk) begin
    logic [127:0] ks_blk;
    cipher_out_t  got, exp_item;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      ksize_reg = '0;
      iv_hi_reg = '0;
      iv_lo_reg = '0;
      ctr = '0;
      for (int i = 0; i < 16; i++) kstream[i] = '0;
      offset = '0;
      expected_bytes.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index) inside
          CFG_KEY0:  key_reg[0] = cfg_data;
          CFG_KEY1:  key_reg[1] = cfg_data;
          CFG_KEY2:  key_reg[2] = cfg_data;
          CFG_KEY3:  key_reg[3] = cfg_data;
          CFG_KSIZE: ksize_reg = cfg_data[1:0];
          CFG_IVHI, CFG_IVLO: begin
            if (cfg_index == CFG_IVHI) iv_hi_reg = cfg_data;
            else iv_lo_reg = cfg_data;
            ctr = {iv_hi_reg, iv_lo_reg};
            offset = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (offset == 4'd0) begin
          ks_blk = encrypt_block(ctr);
          for (int i = 0; i < 16; i++) kstream[i] = ks_blk[127 - 8*i -: 8];
          ctr = ctr + 128'd1;
        end
        expected_bytes.push_back('{cipher_byte: in_data_byte ^ kstream[offset],
                                   last: in_last_in});
        offset = offset + 4'd1;
      end
      if (out_valid && out_ready) begin
        got = '{cipher_byte: out_out_byte, last: out_last_out};
        if (expected_bytes.size() == 0) begin
          if (mismatches < 10) $display("unexpected output byte %h last %b", out_out_byte,
                                        out_last_out);
          mismatches <= mismatches + 1;
        end else begin
          exp_item = expected_bytes.pop_front();
          if (got !== exp_item) begin
            if (mismatches < 10)
              $display("mismatch: expected byte %h last %b, got byte %h last %b",
                       exp_item.cipher_byte, exp_item.last, got.cipher_byte, got.last);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

@@ verif/aes_ctr_byte_stream_cipher_core_tb.sv @@
// testbench top for the aes ctr byte stream cipher core: clock, reset, config and byte stimulus
// depends on acb_pkg, the core and aes_ctr_byte_stream_cipher_core_checker
module aes_ctr_byte_stream_cipher_core_tb import acb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KSizeFull   = 2'd2;
  localparam logic [1:0] KSizeUnused = 2'd3;
  localparam logic [2:0] CfgBadIndex = 3'd7;
  localparam int         DrainCycles = 120;
  localparam int         StallLimit  = 4000;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_last_in;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_ready, out_last_out;
  logic [7:0]  out_out_byte;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          mismatches, pending;
  bit          long_hold;
  int          idle_cycles;

  aes_ctr_byte_stream_cipher_core DUT (.*);
  aes_ctr_byte_stream_cipher_core_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic last);
    int gap;
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_in   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block must be idle before any register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] k0, input logic [63:0] k1,
                         input logic [63:0] k2, input logic [63:0] k3, input logic [1:0] ks);
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_KSIZE, {62'd0, ks});
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
  endtask

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // receiver: random ready with an occasional long hold-off on request
  initial begin
    int r, n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          out_ready <= 1'b0;
          n = $urandom_range(20, 70);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_last_in   <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    long_hold    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key and counter, extreme bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h5a, 1'b0);
    drain();

    // aes-128, counter low half about to carry into high half
    set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0, KSIZE_128);
    write_reg(CFG_IVHI, 64'hf0f1f2f3f4f5f6f7);
    write_reg(CFG_IVLO, '1);
    send_random(18);
    drain();

    // aes-192 then unused size code behaving as 256, full counter wrap
    set_key(64'h8e73b0f7da0e6452, 64'hc810f32b809079e5, 64'h62f8ead2522c6b7b, '1, KSIZE_192);
    write_reg(CFG_IVHI, '1);
    write_reg(CFG_IVLO, '1);
    send_random(17);
    drain();
    write_reg(CFG_KSIZE, {62'd0, KSizeUnused});
    write_reg(CfgBadIndex, '1);
    send_random(5);
    drain();

    // key change part way through a keystream block
    write_reg(CFG_KEY0, 64'h603deb1015ca71be);
    write_reg(CFG_KSIZE, {62'd0, KSizeFull});
    send_random(14);
    drain();

    // random phases with random or extreme settings
    for (int ph = 0; ph < 8; ph++) begin
      set_key(rand_word(), rand_word(), rand_word(), rand_word(), 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_IVHI, rand_word());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_IVLO, rand_word());
      if ($urandom_range(0, 4) == 0) write_reg(CfgBadIndex, rand_word());
      if (ph == 3) long_hold = 1'b1;
      send_random(50);
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/acb_pkg.sv
design/acb_engine.sv
design/aes_ctr_byte_stream_cipher_core.sv
verif/aes_ctr_byte_stream_cipher_core_checker.sv
verif/aes_ctr_byte_stream_cipher_core_tb.sv
